// File: design/ftfm_pkg.sv
package ftfm_pkg;

    localparam int STAMP_W = 32;
    localparam int SCALE_W = 20;
    localparam int FREQ_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(SCALE_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELOAD_VALUE = 3'd0,
        CFG_RATE_SCALE   = 3'd1,
        CFG_ACCEPT_LOW   = 3'd2,
        CFG_ACCEPT_HIGH  = 3'd3,
        CFG_STALE_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        CMD_CAPTURE = 1'b0,
        CMD_REPORT  = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIVIDE,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    // Reset values of the configuration registers.
    localparam logic [STAMP_W-1:0] RELOAD_RESET = 32'hFFFF_FFFF;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 20'd2500;
    localparam logic [FREQ_W-1:0]  LOW_RESET    = 8'd13;
    localparam logic [FREQ_W-1:0]  HIGH_RESET   = 8'd50;
    localparam logic [FREQ_W-1:0]  STALE_RESET  = 8'd15;

endpackage

// File: design/fan_tachometer_frequency_meter.sv
// Two-channel fan tachometer frequency meter.
// The input channel (s_*) carries one item per tach capture event or report
// tick. s_tuser bit 0 is the command (capture event or report tick) and bit 1
// is the fan channel; s_tdata holds the captured 32-bit timer stamp.
// Captures on a channel alternate between a first and a second stamp. The
// second stamp yields the period, corrected for one timer wrap with the
// reload value, and the frequency rate_scale / period from a bit-serial
// restoring divider that retires one quotient bit per cycle.
// A first-phase capture is absorbed at the accept edge, so the next item can
// follow in the next cycle. A second-phase capture runs the period state,
// twenty divider steps and the update state when the period is nonzero, and
// skips the divider when it is zero; no new item is taken until the block is
// back in idle. A report tick emits NUM_CHANNELS result items on m_*, one per
// cycle while m_tready is high; m_tdata is the frequency, m_tuser the channel
// and m_tlast marks the final item of the report.
// Results sit in an output register, so a stall on m_tready only holds the
// report sequence; a new input item is taken once the block is back in idle
// even if the final result still waits there. Reset (aresetn low, synchronous)
// clears all channel state and loads the default configuration.
module fan_tachometer_frequency_meter #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [ftfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ftfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ftfm_pkg::STAMP_W-1:0]        s_tdata,   // [31:0] capture_stamp
    input  logic [1:0]                          s_tuser,   // [0] command, [1] channel
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ftfm_pkg::FREQ_W-1:0]         m_tdata,   // [7:0] frequency
    output logic [0:0]                          m_tuser,   // [0] channel_res
    output logic                                m_tlast
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int STAMP_W = ftfm_pkg::STAMP_W;
    localparam int SCALE_W = ftfm_pkg::SCALE_W;
    localparam int FREQ_W  = ftfm_pkg::FREQ_W;

    // Configuration registers.
    logic [STAMP_W-1:0] reload_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [FREQ_W-1:0]  low_reg;
    logic [FREQ_W-1:0]  high_reg;
    logic [FREQ_W-1:0]  stale_reg;

    // Per-channel state.
    logic               phase_reg [NUM_CHANNELS];
    logic [STAMP_W-1:0] first_reg [NUM_CHANNELS];
    logic [STAMP_W-1:0] period_reg[NUM_CHANNELS];
    logic [FREQ_W-1:0]  cur_reg   [NUM_CHANNELS];
    logic [FREQ_W-1:0]  prev_reg  [NUM_CHANNELS];

    // Working registers.
    ftfm_pkg::state_t             state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg;
    logic [STAMP_W-1:0]           stamp_reg;
    logic [STAMP_W-1:0]           div_reg;
    logic [STAMP_W-1:0]           rem_reg;
    logic [SCALE_W-1:0]           dq_reg;
    logic [ftfm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                         zero_reg;

    // Output register.
    logic              m_tvalid_reg;
    logic [FREQ_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              m_tlast_reg;

    logic               in_accept;
    logic               in_report;
    logic [IDX_W-1:0]   in_idx;
    logic               in_ch_ok;
    logic               slot_free;
    logic               out_load;
    logic               idx_last;
    logic [STAMP_W-1:0] new_period;
    logic [STAMP_W:0]   trial;
    logic               trial_ge;
    logic [SCALE_W-1:0] quotient;
    logic               q_reject;
    logic               stale_clr;

    assign in_accept = s_tvalid && s_tready;
    assign in_report = (s_tuser[0] == ftfm_pkg::CMD_REPORT);
    assign in_idx    = IDX_W'(s_tuser[1]);
    assign in_ch_ok  = (32'(s_tuser[1]) < NUM_CHANNELS);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign idx_last  = (32'(idx_reg) == NUM_CHANNELS - 1);

    // Period with one wrap correction; equal stamps keep the old period.
    always_comb begin
        if (stamp_reg > first_reg[idx_reg]) begin
            new_period = stamp_reg - first_reg[idx_reg];
        end else if (stamp_reg < first_reg[idx_reg]) begin
            new_period = reload_reg - first_reg[idx_reg] + stamp_reg;
        end else begin
            new_period = period_reg[idx_reg];
        end
    end

    // One restoring division step.
    assign trial    = {rem_reg, dq_reg[SCALE_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});

    assign quotient = zero_reg ? '0 : dq_reg;
    assign q_reject = (quotient > SCALE_W'(high_reg)) || (quotient <= SCALE_W'(low_reg));

    assign stale_clr = (cur_reg[idx_reg] == prev_reg[idx_reg]) &&
                       (cur_reg[idx_reg] < stale_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ftfm_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (in_report) begin
                        state_next = ftfm_pkg::ST_REPORT;
                    end else if (in_ch_ok && phase_reg[in_idx]) begin
                        state_next = ftfm_pkg::ST_PERIOD;
                    end
                end
            end
            ftfm_pkg::ST_PERIOD: begin
                state_next = (new_period == '0) ? ftfm_pkg::ST_UPDATE : ftfm_pkg::ST_DIVIDE;
            end
            ftfm_pkg::ST_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = ftfm_pkg::ST_UPDATE;
                end
            end
            ftfm_pkg::ST_UPDATE: begin
                state_next = ftfm_pkg::ST_IDLE;
            end
            ftfm_pkg::ST_REPORT: begin
                if (slot_free && idx_last) begin
                    state_next = ftfm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ftfm_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and strobe logic.
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ftfm_pkg::ST_IDLE:   s_tready = 1'b1;
            ftfm_pkg::ST_REPORT: out_load = slot_free;
            default: begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ftfm_pkg::ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            reload_reg   <= ftfm_pkg::RELOAD_RESET;
            scale_reg    <= ftfm_pkg::SCALE_RESET;
            low_reg      <= ftfm_pkg::LOW_RESET;
            high_reg     <= ftfm_pkg::HIGH_RESET;
            stale_reg    <= ftfm_pkg::STALE_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                phase_reg[i]  <= 1'b0;
                first_reg[i]  <= '0;
                period_reg[i] <= '0;
                cur_reg[i]    <= '0;
                prev_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_index)
                    ftfm_pkg::CFG_RELOAD_VALUE: reload_reg <= cfg_data;
                    ftfm_pkg::CFG_RATE_SCALE:   scale_reg  <= cfg_data[SCALE_W-1:0];
                    ftfm_pkg::CFG_ACCEPT_LOW:   low_reg    <= cfg_data[FREQ_W-1:0];
                    ftfm_pkg::CFG_ACCEPT_HIGH:  high_reg   <= cfg_data[FREQ_W-1:0];
                    ftfm_pkg::CFG_STALE_LIMIT:  stale_reg  <= cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ftfm_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        idx_reg <= in_report ? '0 : in_idx;
                        if (!in_report && in_ch_ok) begin
                            // Every capture event moves the current reading to previous.
                            prev_reg[in_idx] <= cur_reg[in_idx];
                            if (!phase_reg[in_idx]) begin
                                first_reg[in_idx] <= s_tdata;
                                phase_reg[in_idx] <= 1'b1;
                            end
                        end
                    end
                end
                ftfm_pkg::ST_PERIOD: begin
                    period_reg[idx_reg] <= new_period;
                end
                ftfm_pkg::ST_UPDATE: begin
                    cur_reg[idx_reg]   <= q_reject ? prev_reg[idx_reg] : quotient[FREQ_W-1:0];
                    phase_reg[idx_reg] <= 1'b0;
                end
                ftfm_pkg::ST_REPORT: begin
                    if (slot_free) begin
                        if (stale_clr) begin
                            cur_reg[idx_reg]  <= '0;
                            prev_reg[idx_reg] <= '0;
                        end
                        idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            stamp_reg <= s_tdata;
        end
        case (state_reg)
            ftfm_pkg::ST_PERIOD: begin
                div_reg  <= new_period;
                rem_reg  <= '0;
                dq_reg   <= scale_reg;
                cnt_reg  <= ftfm_pkg::DIV_CNT_W'(SCALE_W - 1);
                zero_reg <= (new_period == '0);
            end
            ftfm_pkg::ST_DIVIDE: begin
                rem_reg <= trial_ge ? STAMP_W'(trial - {1'b0, div_reg}) : trial[STAMP_W-1:0];
                dq_reg  <= {dq_reg[SCALE_W-2:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= stale_clr ? '0 : cur_reg[idx_reg];
            m_tuser_reg <= idx_reg[0];
            m_tlast_reg <= idx_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // The divider never runs with a zero divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ftfm_pkg::ST_DIVIDE) |-> (div_reg != '0))
        else $error("divider running with zero divisor");

    // The partial remainder stays below the divisor throughout a division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ftfm_pkg::ST_DIVIDE) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    // Loading the final result of a report returns the block to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && idx_last) |=> (state_reg == ftfm_pkg::ST_IDLE && m_tvalid && m_tlast))
        else $error("report did not end on its final item");

    // A result is only loaded while the output register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
